/* sv/linear_probe_hash_upsert_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash upsert block
// Shared concurrent assertion wrappers used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_UPSERT_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_UPSERT_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define LPHU_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the trigger holds, the property must hold at the next clock edge.
`define LPHU_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

/* sv/lphu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash upsert package
// Table geometry, field widths, slot layout, codes and the controller
// command and status bundles.
// ----------------------------------------------------------------------------
package lphu_pkg;

    localparam int CAPACITY   = 1024;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;
    localparam int HASH_W     = 32;
    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int LIMIT_W    = 4;
    localparam int LOAD_DENOM = 10;
    localparam int GROW_W     = CNT_W + 4;

    localparam logic [LIMIT_W-1:0] LOAD_RESET = LIMIT_W'(7);

    localparam int IN_W  = HASH_W + KEY_W + VALUE_W;
    localparam int OUT_W = STATUS_W + IDX_W + VALUE_W + CNT_W + 1;

    localparam logic [STATUS_W-1:0] ST_FOUND    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_INSERTED = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(2);

    typedef struct packed {
        logic               filled;
        logic [HASH_W-1:0]  hash;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] data;
    } slot_t;

    typedef enum logic [1:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_PROBE
    } ctl_state_t;

    typedef struct packed {
        logic clear_wr;
        logic start;
        logic advance;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit_empty;
        logic hit_match;
        logic probe_last;
        logic out_busy;
    } dp_status_t;

endpackage

/* sv/lphu_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash upsert datapath
// Slot memory, probe address and counters, fill count, load limit register
// and the result register.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_upsert_top_defines.svh"

module lphu_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lphu_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lphu_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_wr_en,
    input  logic [lphu_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  lphu_pkg::ctl_cmd_t          cmd,
    output lphu_pkg::dp_status_t        st
);
    import lphu_pkg::*;

    slot_t               mem [CAPACITY];
    slot_t               rd_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    slot_t               wr_data;

    logic [IDX_W-1:0]    clr_addr_reg;
    logic [IDX_W-1:0]    probe_reg;
    logic [IDX_W-1:0]    steps_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic                hit_empty;
    logic                hit_match;
    logic [STATUS_W-1:0] res_status;
    logic [IDX_W-1:0]    res_index;
    logic [VALUE_W-1:0]  res_value;
    logic [GROW_W-1:0]   load_lhs;
    logic [GROW_W-1:0]   load_rhs;
    logic                res_grow;

    assign hit_empty = !rd_reg.filled;
    assign hit_match = rd_reg.filled && (rd_reg.hash == hash_reg) && (rd_reg.key == key_reg);

    always_comb begin
        priority if (cmd.start) begin
            rd_addr = s_tdata[IDX_W-1:0];
        end else if (cmd.advance) begin
            rd_addr = probe_reg + IDX_W'(1);
        end else begin
            rd_addr = probe_reg;
        end
    end

    assign wr_en   = cmd.clear_wr || (cmd.load_out && hit_empty);
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : probe_reg;
    assign wr_data = cmd.clear_wr ? slot_t'('0) : slot_t'{1'b1, hash_reg, key_reg, value_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb begin
        fill_next = fill_reg + CNT_W'(hit_empty);
        if (hit_empty) begin
            res_status = ST_INSERTED;
            res_index  = probe_reg;
            res_value  = value_reg;
        end else if (hit_match) begin
            res_status = ST_FOUND;
            res_index  = probe_reg;
            res_value  = rd_reg.data;
        end else begin
            res_status = ST_FULL;
            res_index  = '0;
            res_value  = '0;
        end
        load_lhs = GROW_W'(fill_next) * GROW_W'(LOAD_DENOM);
        load_rhs = GROW_W'(limit_reg) * GROW_W'(CAPACITY);
        res_grow = load_lhs >= load_rhs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            fill_reg     <= '0;
            limit_reg    <= LOAD_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.load_out) begin
                fill_reg     <= fill_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            hash_reg  <= s_tdata[HASH_W-1:0];
            key_reg   <= s_tdata[HASH_W +: KEY_W];
            value_reg <= s_tdata[HASH_W+KEY_W +: VALUE_W];
            probe_reg <= s_tdata[IDX_W-1:0];
            steps_reg <= '0;
        end else if (cmd.advance) begin
            probe_reg <= probe_reg + IDX_W'(1);
            steps_reg <= steps_reg + IDX_W'(1);
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {res_grow, fill_next, res_value, res_index, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign st.clear_last = clr_addr_reg == IDX_W'(CAPACITY - 1);
    assign st.hit_empty  = hit_empty;
    assign st.hit_match  = hit_match;
    assign st.probe_last = steps_reg == IDX_W'(CAPACITY - 1);
    assign st.out_busy   = m_tvalid_reg && !m_tready;

    `LPHU_ASSERT_HOLDS(a_fill_bound, aclk, aresetn, fill_reg <= CNT_W'(CAPACITY),
        "fill count exceeds the table capacity")
    `LPHU_ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.load_out, m_tvalid_reg,
        "result register not valid after a load")
    `LPHU_ASSERT_NEXT(a_fill_stable, aclk, aresetn, cmd.load_out && !hit_empty,
        fill_reg == $past(fill_reg), "fill count changed without an insertion")

endmodule

/* sv/lphu_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash upsert controller
// Sequences the clearing pass, input acceptance and the slot probe loop.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_upsert_top_defines.svh"

module lphu_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lphu_pkg::dp_status_t st,
    output lphu_pkg::ctl_cmd_t   cmd
);
    import lphu_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       decided;

    assign decided = st.hit_empty || st.hit_match || st.probe_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CTL_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last) begin
                    state_next = CTL_IDLE;
                end
            end
            CTL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = CTL_PROBE;
                end
            end
            CTL_PROBE: begin
                if (decided) begin
                    if (!st.out_busy) begin
                        cmd.load_out = 1'b1;
                        state_next   = CTL_IDLE;
                    end
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    `LPHU_ASSERT_HOLDS(a_no_accept_in_clear, aclk, aresetn,
        !(state_reg == CTL_CLEAR && s_tready), "input accepted during the clearing pass")
    `LPHU_ASSERT_HOLDS(a_load_not_busy, aclk, aresetn, !(cmd.load_out && st.out_busy),
        "result loaded while the previous word is still held")
    `LPHU_ASSERT_HOLDS(a_advance_undecided, aclk, aresetn, !(cmd.advance && decided),
        "probe advanced past a decided slot")

endmodule

/* sv/linear_probe_hash_upsert_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash upsert top level
// Open-addressing hash table with linear probing, stream in and stream out.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the slot memory with
// s_tready low; configuration writes are taken during it. Each word is then
// accepted in the idle state and probed slot by slot from its home slot
// until an empty or matching slot decides it or every slot has been probed.
// The probe loop visits one slot per cycle, set by the single read port
// of the slot memory. A finished result sits in an output register, and
// the next word is accepted and probed while it waits.

module linear_probe_hash_upsert_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: hash, key, insert value
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lphu_pkg::IN_W-1:0]    s_tdata,
    // m_tdata: status, slot_index, stored_value, entry_count, grow_needed
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lphu_pkg::OUT_W-1:0]   m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [lphu_pkg::LIMIT_W-1:0] cfg_wr_data
);
    import lphu_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t st;

    lphu_controller u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lphu_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

/* tb/sv/linear_probe_hash_upsert_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash upsert regression
// Streams upsert words into the hash table and checks every result word
// against a behavioral copy of the table, across several load limits, from
// an empty table to a full one, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module linear_probe_hash_upsert_top_test;

    import lphu_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] insert_value;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  hash;
    } upsert_in_t;

    typedef struct packed {
        logic                grow;
        logic [CNT_W-1:0]    count;
        logic [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]    slot;
        logic [STATUS_W-1:0] status;
    } upsert_out_t;

    localparam int FULL_CAP = 30;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;

    linear_probe_hash_upsert_top DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Shadow of the table contents.
    logic               tbl_used [CAPACITY];
    logic [HASH_W-1:0]  tbl_hash [CAPACITY];
    logic [KEY_W-1:0]   tbl_key  [CAPACITY];
    logic [VALUE_W-1:0] tbl_value[CAPACITY];
    logic [CNT_W-1:0]   tbl_count = '0;
    logic [LIMIT_W-1:0] load_limit = LOAD_RESET;

    upsert_in_t  pending_words[$];
    upsert_out_t predicted_upserts[$];
    logic [HASH_W-1:0] known_hash[$];
    logic [KEY_W-1:0]  known_key[$];
    logic [IDX_W-1:0]  next_home = '0;

    int words_queued = 0;
    int words_accepted = 0;
    int full_tries = 0;
    int mismatches = 0;
    int seen_found = 0;
    int seen_inserted = 0;
    int seen_full = 0;
    int src_gap = 0;
    int sink_gap = 0;
    bit quiet = 1'b0;
    logic sink_hold = 1'b0;

    initial begin
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_used[i] = 1'b0;
        end
    end

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic upsert_out_t upsert_table(upsert_in_t w);
        upsert_out_t r;
        int unsigned s;
        bit done;
        r.status = ST_FULL;
        r.slot = '0;
        r.value = '0;
        done = 1'b0;
        for (int i = 0; i < CAPACITY && !done; i++) begin
            s = (w.hash % CAPACITY + i) % CAPACITY;
            if (!tbl_used[s]) begin
                tbl_used[s] = 1'b1;
                tbl_hash[s] = w.hash;
                tbl_key[s] = w.key;
                tbl_value[s] = w.insert_value;
                tbl_count = tbl_count + 1'b1;
                r.status = ST_INSERTED;
                r.slot = IDX_W'(s);
                r.value = w.insert_value;
                done = 1'b1;
            end else if (tbl_hash[s] == w.hash && tbl_key[s] == w.key) begin
                r.status = ST_FOUND;
                r.slot = IDX_W'(s);
                r.value = tbl_value[s];
                done = 1'b1;
            end
        end
        r.count = tbl_count;
        r.grow = (int'(tbl_count) * LOAD_DENOM >= CAPACITY * int'(load_limit));
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        upsert_out_t got;
        upsert_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                case (got.status)
                    ST_FOUND: seen_found++;
                    ST_INSERTED: seen_inserted++;
                    default: seen_full++;
                endcase
                if (predicted_upserts.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = predicted_upserts.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("slot_index", 64'(want.slot), 64'(got.slot));
                    check_field("stored_value", want.value, got.value);
                    check_field("entry_count", 64'(want.count), 64'(got.count));
                    check_field("grow_needed", 64'(want.grow), 64'(got.grow));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
            end else if (!quiet && $urandom_range(7) == 0) begin
                sink_gap = $urandom_range(1, 9);
            end
            m_tready <= (sink_gap == 0) && !sink_hold;
        end
    end

    always @(posedge aclk) begin
        bit fire;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire) begin
                predicted_upserts.push_back(upsert_table(upsert_in_t'(s_tdata)));
                words_accepted++;
                if (!quiet && $urandom_range(3) == 0) begin
                    src_gap = $urandom_range(1, 9);
                end
            end
            if (!s_tvalid || fire) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_words.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long sink stall while the source keeps offering words.
    initial begin
        while (words_accepted < 100) @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (600) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    task automatic queue_word(logic [HASH_W-1:0] h, logic [KEY_W-1:0] k,
                              logic [VALUE_W-1:0] v);
        upsert_in_t w;
        w.hash = h;
        w.key = k;
        w.insert_value = v;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_new(logic [HASH_W-1:0] h, logic [KEY_W-1:0] k,
                             logic [VALUE_W-1:0] v);
        known_hash.push_back(h);
        known_key.push_back(k);
        queue_word(h, k, v);
    endtask

    task automatic queue_random(int n, int new_pct);
        logic [HASH_W-1:0] h;
        logic [KEY_W-1:0] k;
        int pick;
        int bit_sel;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < new_pct &&
                (known_hash.size() < CAPACITY || full_tries < FULL_CAP)) begin
                if (known_hash.size() >= CAPACITY) begin
                    full_tries++;
                end
                pick = $urandom_range(9);
                if (pick < 7) begin
                    h = $urandom;
                    h[IDX_W-1:0] = next_home;
                    next_home = next_home + 1'b1;
                    k = {$urandom, $urandom};
                end else if (pick < 9) begin
                    h = $urandom;
                    k = {$urandom, $urandom};
                end else begin
                    pick = $urandom_range(known_hash.size() - 1);
                    h = known_hash[pick];
                    k = known_key[pick];
                    if ($urandom_range(1) == 1) begin
                        bit_sel = $urandom_range(KEY_W - 1);
                        k[bit_sel] = ~k[bit_sel];
                    end else begin
                        bit_sel = $urandom_range(HASH_W - 1);
                        h[bit_sel] = ~h[bit_sel];
                    end
                end
                queue_new(h, k, {$urandom, $urandom});
            end else begin
                pick = $urandom_range(known_hash.size() - 1);
                queue_word(known_hash[pick], known_key[pick], {$urandom, $urandom});
            end
        end
    endtask

    task automatic drain();
        while (words_accepted != words_queued || predicted_upserts.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_load_limit(logic [LIMIT_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        load_limit = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_load_limit(LIMIT_W'(0));

        queue_new(32'h0000_0000, 64'h0, 64'h0);
        queue_word(32'h0000_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_new(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_new(32'h0000_03FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555);
        queue_word(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        queue_new(32'h0000_0000, 64'h1, 64'h1234_5678_9ABC_DEF0);
        queue_new(32'h0000_0400, 64'h0, 64'h0F0F_0F0F_0F0F_0F0F);
        queue_word(32'h0000_0400, 64'h0, 64'h0);
        queue_new(32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_new(32'h5555_5555, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_new(32'h8000_0000, 64'h8000_0000_0000_0000, 64'h1);
        queue_word(32'h8000_0000, 64'h8000_0000_0000_0000, 64'h2);
        queue_word(32'h0000_03FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        queue_word(32'h0000_0000, 64'h1, 64'h0);
        drain();

        write_load_limit(LIMIT_W'(1));
        queue_random(350, 65);
        drain();

        write_load_limit(LIMIT_W'(15));
        queue_random(300, 55);
        drain();

        write_load_limit(LIMIT_W'(7));
        queue_random(400, 90);
        drain();

        write_load_limit(LIMIT_W'(10));
        queue_random(500, 80);
        drain();

        quiet = 1'b1;
        write_load_limit(LIMIT_W'(11));
        queue_random(200, 10);
        drain();

        repeat (1100) @(posedge aclk);
        $display("Covered %0d upsert words: %0d found, %0d inserted, %0d table full.",
                 words_accepted, seen_found, seen_inserted, seen_full);
        $display("Load limits 0, 1, 15, 7, 10 and 11 applied; final entry count %0d.",
                 tbl_count);
        if (mismatches == 0) begin
            $display("linear_probe_hash_upsert_top regression: pass");
        end else begin
            $display("linear_probe_hash_upsert_top regression: fail");
        end
        $finish;
    end

    initial begin
        #250_000_000;
        $display("Run timed out with %0d words still expected.", predicted_upserts.size());
        $display("linear_probe_hash_upsert_top regression: fail");
        $finish;
    end

endmodule
